/* hw/rtl/sctf_pkg.sv */
// Package for the serial channel with translating FIFOs.
// Operation and register codes, result records, byte translation helpers.
// No dependencies.
package sctf_pkg;

	typedef enum logic [3:0] {
		OP_PUT    = 4'd0,
		OP_GET    = 4'd1,
		OP_STATUS = 4'd2,
		OP_TICK   = 4'd3,
		OP_MODEM  = 4'd4,
		OP_TERM   = 4'd5,
		OP_OPEN   = 4'd6,
		OP_CLOSE  = 4'd7,
		OP_CONC   = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		REG_TRANS  = 3'd0,
		REG_HEAVY  = 3'd1,
		REG_ADDLF  = 3'd2,
		REG_REPL   = 3'd3,
		REG_STRIP  = 3'd4,
		REG_PARITY = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		PAR_NONE = 2'd0,
		PAR_ODD  = 2'd1,
		PAR_EVEN = 2'd2,
		PAR_MARK = 2'd3
	} par_mode_t;

	localparam logic [7:0] CH_EOL     = 8'h9B;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] PRINT_BASE = 8'h20;
	localparam logic [7:0] PRINT_SPAN = 8'h5C;
	localparam logic [7:0] LS_KEEP    = 8'hA8;
	localparam logic [7:0] LOW7_MASK  = 8'h7F;
	localparam logic [7:0] FRAME_ERR  = 8'h80;
	localparam logic [7:0] CD_ON      = 8'h08;
	localparam logic [7:0] CTS_ON     = 8'h20;
	localparam logic [7:0] DSR_ON     = 8'h80;

	// result of an item before the memory read data is joined in
	typedef struct packed {
		logic       ok;
		logic       rd_pend;
		logic [7:0] status_errors;
		logic [7:0] status_lines;
		logic [5:0] input_count;
		logic [5:0] output_count;
		logic       tx_valid;
		logic       rx_accepted;
		logic       dtr_level;
		logic       rts_level;
		logic       terminal_changed;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] read_byte;
		logic [7:0] status_errors;
		logic [7:0] status_lines;
		logic [5:0] input_count;
		logic [5:0] output_count;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_accepted;
		logic       dtr_level;
		logic       rts_level;
		logic       terminal_changed;
	} out_t;

	function automatic logic [7:0] tx_parity(input logic [7:0] c, input par_mode_t m);
		logic       p;
		logic [7:0] r;
		p = ^c[6:0];
		case (m)
			PAR_ODD:  r = {~p, c[6:0]};
			PAR_EVEN: r = {p, c[6:0]};
			PAR_MARK: r = {1'b1, c[6:0]};
			default:  r = c;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] rx_xlate(input logic [7:0] c, input logic strip,
			input logic te, input logic heavy, input logic [7:0] repl);
		logic [7:0] r;
		r = c;
		if (strip)
			r = r & LOW7_MASK;
		if (te) begin
			r = r & LOW7_MASK;
			if (r == CH_CR)
				r = CH_EOL;
			else if (heavy && (8'(r - PRINT_BASE) > PRINT_SPAN))
				r = repl;
		end
		return r;
	endfunction

	// pair per line: 00 always off, 01 now off, 10 now on, 11 always on
	function automatic logic [7:0] track_line(input logic [7:0] st, input logic level,
			input logic [7:0] on_bit);
		logic [7:0] pair;
		logic [7:0] r;
		pair = on_bit | (on_bit >> 1);
		r = st;
		if (level) begin
			if ((st & on_bit) == 8'h00)
				r = (st & ~pair) | on_bit;
		end else begin
			if ((st & on_bit) != 8'h00)
				r = (st & ~pair) | (on_bit >> 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] status_decay(input logic [7:0] ls);
		logic [7:0] k;
		k = ls & LS_KEEP;
		return 8'(k + (k >> 1));
	endfunction

endpackage

/* hw/rtl/sctf_if.sv */
// Request and result channels of the serial channel block.
// Valid/ready handshake with the item fields as payload. No dependencies.
interface sctf_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] operation;
	logic [7:0] host_byte;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic       rx_framing_error;
	logic       carrier_detect;
	logic       clear_to_send;
	logic       data_set_ready;

	modport source (output valid, operation, host_byte, rx_valid, rx_byte, rx_framing_error,
		carrier_detect, clear_to_send, data_set_ready, input ready);
	modport sink (input valid, operation, host_byte, rx_valid, rx_byte, rx_framing_error,
		carrier_detect, clear_to_send, data_set_ready, output ready);
endinterface

interface sctf_out_if;
	logic       valid;
	logic       ready;
	logic       ok;
	logic [7:0] read_byte;
	logic [7:0] status_errors;
	logic [7:0] status_lines;
	logic [5:0] input_count;
	logic [5:0] output_count;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       rx_accepted;
	logic       dtr_level;
	logic       rts_level;
	logic       terminal_changed;

	modport source (output valid, ok, read_byte, status_errors, status_lines, input_count,
		output_count, tx_valid, tx_byte, rx_accepted, dtr_level, rts_level, terminal_changed,
		input ready);
	modport sink (input valid, ok, read_byte, status_errors, status_lines, input_count,
		output_count, tx_valid, tx_byte, rx_accepted, dtr_level, rts_level, terminal_changed,
		output ready);
endinterface

/* hw/rtl/serial_channel_translate_fifo.sv */
// Serial channel with translating receive and transmit FIFOs.
// A request updates state and reads the FIFO memory at the edge that accepts it; the result
// register is loaded from these when the output can take it, and the result is then offered.
// Throughput: one request per cycle unless the output stalls; a put that queues CR then LF holds
// the input while the LF is written into the transmit memory.
// Reset: pointers, levels, flags and configuration reset at once; FIFO contents are not cleared.
module serial_channel_translate_fifo
	import sctf_pkg::*;
#(
	parameter int RX_DEPTH = 32,
	parameter int TX_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	sctf_in_if.sink     in_ch,
	sctf_out_if.source  out_ch
);

	localparam int RXA = $clog2(RX_DEPTH);
	localparam int RXL = $clog2(RX_DEPTH + 1);
	localparam int TXA = $clog2(TX_DEPTH);
	localparam int TXL = $clog2(TX_DEPTH + 1);

	// configuration
	logic       trans_q, heavy_q, addlf_q, strip_q;
	logic [7:0] repl_q;
	par_mode_t  parity_q;
	reg_idx_t   cfg_idx;
	logic       cfg_wr;

	// channel state
	logic [RXA-1:0] rx_rptr_q, rx_rptr_d, rx_wptr_q, rx_wptr_d;
	logic [RXL-1:0] rx_lvl_q, rx_lvl_d;
	logic [TXA-1:0] tx_rptr_q, tx_rptr_d, tx_wptr_q, tx_wptr_d;
	logic [TXL-1:0] tx_lvl_q, tx_lvl_d;
	logic [7:0]     line_q, line_d;
	logic           frame_q, frame_d, lf_pend_q, lf_pend_d, conc_q, conc_d;
	logic           dtr_q, dtr_d, rts_q, rts_d;

	// second LF write
	logic           lf_wr_q, lf_wr_d;
	logic [TXA-1:0] lf_addr_q, lf_addr_d;

	// memory ports
	logic           rx_we, rx_re, tx_acc_we, tx_we, tx_re;
	logic [7:0]     tx_acc_wdata, tx_wdata, rx_rdata, tx_rdata;
	logic [TXA-1:0] tx_waddr;

	// pipeline
	logic in_fire, s1_adv, s1_valid_q, out_valid_q;
	res_t res_d, res_s1;
	out_t out_d, out_q;

	// request decode temporaries
	op_t            op;
	logic           ok, drop, tchg, txv, rxa;
	logic [7:0]     ch, serr, slines;
	logic           rx_full, tx_full;
	logic [RXA-1:0] rx_rptr_p1, rx_wptr_p1;
	logic [TXA-1:0] tx_rptr_p1, tx_wptr_p1, tx_wptr_p2;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_q  <= 1'b1;
			heavy_q  <= 1'b1;
			addlf_q  <= 1'b0;
			repl_q   <= 8'h00;
			strip_q  <= 1'b0;
			parity_q <= PAR_NONE;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_TRANS:  trans_q  <= pwdata[0];
				REG_HEAVY:  heavy_q  <= pwdata[0];
				REG_ADDLF:  addlf_q  <= pwdata[0];
				REG_REPL:   repl_q   <= pwdata[7:0];
				REG_STRIP:  strip_q  <= pwdata[0];
				REG_PARITY: parity_q <= par_mode_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_TRANS:  prdata = {31'd0, trans_q};
			REG_HEAVY:  prdata = {31'd0, heavy_q};
			REG_ADDLF:  prdata = {31'd0, addlf_q};
			REG_REPL:   prdata = {24'd0, repl_q};
			REG_STRIP:  prdata = {31'd0, strip_q};
			REG_PARITY: prdata = {30'd0, parity_q};
			default:    prdata = 32'd0;
		endcase
	end

	// handshake
	assign s1_adv      = s1_valid_q && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !lf_wr_q && (!s1_valid_q || s1_adv);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign op          = op_t'(in_ch.operation);

	assign rx_full    = (rx_lvl_q == RXL'(RX_DEPTH));
	assign tx_full    = (tx_lvl_q == TXL'(TX_DEPTH));
	assign rx_rptr_p1 = (rx_rptr_q == RXA'(RX_DEPTH - 1)) ? '0 : rx_rptr_q + 1'b1;
	assign rx_wptr_p1 = (rx_wptr_q == RXA'(RX_DEPTH - 1)) ? '0 : rx_wptr_q + 1'b1;
	assign tx_rptr_p1 = (tx_rptr_q == TXA'(TX_DEPTH - 1)) ? '0 : tx_rptr_q + 1'b1;
	assign tx_wptr_p1 = (tx_wptr_q == TXA'(TX_DEPTH - 1)) ? '0 : tx_wptr_q + 1'b1;
	assign tx_wptr_p2 = (tx_wptr_p1 == TXA'(TX_DEPTH - 1)) ? '0 : tx_wptr_p1 + 1'b1;

	always_comb begin
		rx_rptr_d    = rx_rptr_q;
		rx_wptr_d    = rx_wptr_q;
		rx_lvl_d     = rx_lvl_q;
		tx_rptr_d    = tx_rptr_q;
		tx_wptr_d    = tx_wptr_q;
		tx_lvl_d     = tx_lvl_q;
		line_d       = line_q;
		frame_d      = frame_q;
		lf_pend_d    = lf_pend_q;
		conc_d       = conc_q;
		dtr_d        = dtr_q;
		rts_d        = rts_q;
		lf_wr_d      = 1'b0;
		lf_addr_d    = lf_addr_q;
		rx_we        = 1'b0;
		rx_re        = 1'b0;
		tx_acc_we    = 1'b0;
		tx_acc_wdata = tx_parity(CH_LF, parity_q);
		tx_re        = 1'b0;
		ok           = 1'b0;
		drop         = 1'b0;
		tchg         = 1'b0;
		txv          = 1'b0;
		rxa          = 1'b0;
		serr         = 8'h00;
		slines       = 8'h00;
		ch           = in_ch.host_byte;

		if (in_fire) begin
			unique case (op)
				OP_PUT: begin
					if (lf_pend_q) begin
						if (!tx_full) begin
							tx_acc_we = 1'b1;
							tx_wptr_d = tx_wptr_p1;
							tx_lvl_d  = tx_lvl_q + 1'b1;
							lf_pend_d = 1'b0;
							ok        = 1'b1;
						end
					end else begin
						if (trans_q) begin
							if (ch == CH_EOL)
								ch = CH_CR;
							if (heavy_q) begin
								if ((8'(ch - PRINT_BASE) > PRINT_SPAN) && (ch != CH_CR))
									drop = 1'b1;
							end else begin
								ch = ch & LOW7_MASK;
							end
						end
						if (drop) begin
							ok = 1'b1;
						end else if (!tx_full) begin
							tx_acc_we    = 1'b1;
							tx_acc_wdata = tx_parity(ch, parity_q);
							tx_wptr_d    = tx_wptr_p1;
							tx_lvl_d     = tx_lvl_q + 1'b1;
							ok           = 1'b1;
							if ((ch == CH_CR) && addlf_q && trans_q) begin
								if (tx_lvl_q == TXL'(TX_DEPTH - 1)) begin
									lf_pend_d = 1'b1;
									ok        = 1'b0;
								end else begin
									// LF goes in on the following cycle
									lf_wr_d   = 1'b1;
									lf_addr_d = tx_wptr_p1;
									tx_wptr_d = tx_wptr_p2;
									tx_lvl_d  = tx_lvl_q + TXL'(2);
								end
							end
						end
					end
				end
				OP_GET: begin
					if (rx_lvl_q != '0) begin
						rx_re     = 1'b1;
						rx_rptr_d = rx_rptr_p1;
						rx_lvl_d  = rx_lvl_q - 1'b1;
						ok        = 1'b1;
					end
				end
				OP_STATUS: begin
					serr = frame_q ? FRAME_ERR : 8'h00;
					if (conc_q) begin
						slines = 8'(rx_lvl_q);
					end else begin
						slines  = line_q;
						frame_d = 1'b0;
					end
					line_d = status_decay(line_q);
					ok     = 1'b1;
				end
				OP_TICK: begin
					if (tx_lvl_q != '0) begin
						txv       = 1'b1;
						tx_re     = 1'b1;
						tx_rptr_d = tx_rptr_p1;
						tx_lvl_d  = tx_lvl_q - 1'b1;
					end
					if (in_ch.rx_valid && !rx_full) begin
						if (in_ch.rx_framing_error)
							frame_d = 1'b1;
						rx_we     = 1'b1;
						rx_wptr_d = rx_wptr_p1;
						rx_lvl_d  = rx_lvl_q + 1'b1;
						rxa       = 1'b1;
					end
					ok = 1'b1;
				end
				OP_MODEM: begin
					line_d = track_line(track_line(track_line(line_q,
						in_ch.carrier_detect, CD_ON), in_ch.clear_to_send, CTS_ON),
						in_ch.data_set_ready, DSR_ON);
					ok = 1'b1;
				end
				OP_TERM: begin
					if (in_ch.host_byte[7] && (in_ch.host_byte[6] != dtr_q)) begin
						dtr_d = in_ch.host_byte[6];
						tchg  = 1'b1;
					end
					if (in_ch.host_byte[5] && (in_ch.host_byte[4] != rts_q)) begin
						rts_d = in_ch.host_byte[4];
						tchg  = 1'b1;
					end
					ok = 1'b1;
				end
				OP_OPEN: begin
					rx_rptr_d = '0;
					rx_wptr_d = '0;
					rx_lvl_d  = '0;
					tx_rptr_d = '0;
					tx_wptr_d = '0;
					tx_lvl_d  = '0;
					frame_d   = 1'b0;
					lf_pend_d = 1'b0;
					conc_d    = 1'b0;
					tchg      = !dtr_q || !rts_q;
					dtr_d     = 1'b1;
					rts_d     = 1'b1;
					ok        = 1'b1;
				end
				OP_CLOSE: begin
					if (tx_lvl_q == '0) begin
						if (conc_q)
							frame_d = 1'b0;
						conc_d = 1'b0;
						ok     = 1'b1;
					end
				end
				OP_CONC: begin
					conc_d    = 1'b1;
					rx_rptr_d = '0;
					rx_wptr_d = '0;
					rx_lvl_d  = '0;
					ok        = 1'b1;
				end
				default: ;
			endcase
		end

		res_d.ok               = ok;
		res_d.rd_pend          = rx_re;
		res_d.status_errors    = serr;
		res_d.status_lines     = slines;
		res_d.input_count      = 6'(rx_lvl_d);
		res_d.output_count     = 6'(tx_lvl_d);
		res_d.tx_valid         = txv;
		res_d.rx_accepted      = rxa;
		res_d.dtr_level        = dtr_d;
		res_d.rts_level        = rts_d;
		res_d.terminal_changed = tchg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_rptr_q <= '0;
			rx_wptr_q <= '0;
			rx_lvl_q  <= '0;
			tx_rptr_q <= '0;
			tx_wptr_q <= '0;
			tx_lvl_q  <= '0;
			line_q    <= 8'h00;
			frame_q   <= 1'b0;
			lf_pend_q <= 1'b0;
			conc_q    <= 1'b0;
			dtr_q     <= 1'b0;
			rts_q     <= 1'b0;
			lf_wr_q   <= 1'b0;
		end else begin
			rx_rptr_q <= rx_rptr_d;
			rx_wptr_q <= rx_wptr_d;
			rx_lvl_q  <= rx_lvl_d;
			tx_rptr_q <= tx_rptr_d;
			tx_wptr_q <= tx_wptr_d;
			tx_lvl_q  <= tx_lvl_d;
			line_q    <= line_d;
			frame_q   <= frame_d;
			lf_pend_q <= lf_pend_d;
			conc_q    <= conc_d;
			dtr_q     <= dtr_d;
			rts_q     <= rts_d;
			lf_wr_q   <= lf_wr_d;
		end
	end

	always_ff @(posedge clk) begin
		lf_addr_q <= lf_addr_d;
	end

	// transmit write port: request write, or the trailing LF
	assign tx_we    = tx_acc_we || lf_wr_q;
	assign tx_waddr = lf_wr_q ? lf_addr_q : tx_wptr_q;
	assign tx_wdata = lf_wr_q ? tx_parity(CH_LF, parity_q) : tx_acc_wdata;

	sctf_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_wptr_q),
		.wdata (in_ch.rx_byte),
		.re    (rx_re),
		.raddr (rx_rptr_q),
		.rdata (rx_rdata)
	);

	sctf_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (tx_wdata),
		.re    (tx_re),
		.raddr (tx_rptr_q),
		.rdata (tx_rdata)
	);

	// result stage: join memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_fire)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			res_s1 <= res_d;
	end

	always_comb begin
		out_d.ok               = res_s1.ok;
		out_d.read_byte        = res_s1.rd_pend ?
			rx_xlate(rx_rdata, strip_q, trans_q, heavy_q, repl_q) : 8'h00;
		out_d.status_errors    = res_s1.status_errors;
		out_d.status_lines     = res_s1.status_lines;
		out_d.input_count      = res_s1.input_count;
		out_d.output_count     = res_s1.output_count;
		out_d.tx_valid         = res_s1.tx_valid;
		out_d.tx_byte          = res_s1.tx_valid ? tx_rdata : 8'h00;
		out_d.rx_accepted      = res_s1.rx_accepted;
		out_d.dtr_level        = res_s1.dtr_level;
		out_d.rts_level        = res_s1.rts_level;
		out_d.terminal_changed = res_s1.terminal_changed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_adv)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			out_q <= out_d;
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.ok               = out_q.ok;
	assign out_ch.read_byte        = out_q.read_byte;
	assign out_ch.status_errors    = out_q.status_errors;
	assign out_ch.status_lines     = out_q.status_lines;
	assign out_ch.input_count      = out_q.input_count;
	assign out_ch.output_count     = out_q.output_count;
	assign out_ch.tx_valid         = out_q.tx_valid;
	assign out_ch.tx_byte          = out_q.tx_byte;
	assign out_ch.rx_accepted      = out_q.rx_accepted;
	assign out_ch.dtr_level        = out_q.dtr_level;
	assign out_ch.rts_level        = out_q.rts_level;
	assign out_ch.terminal_changed = out_q.terminal_changed;

endmodule

/* hw/rtl/sctf_ram.sv */
// Byte FIFO storage: one write port, one read port with registered data.
// Read data holds until the next read. No dependencies.
module sctf_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
